// ===== src/awa_pkg.sv =====
// Shared types and constants for the adaptive window aggregator.
// Used by every module under src except awa_ram; depends on nothing else.
package awa_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LUX_W    = 18;
  localparam int LIM_W    = 13;
  localparam int MODE_W   = 2;
  localparam int SCALE_W  = 14;
  localparam int CFG_IDX_W = 1;

  // Lux in Q.4 is raw * 9375 / 256.
  localparam logic [SCALE_W-1:0] LUX_SCALE = 14'd9375;
  localparam int LUX_SHIFT = 8;

  localparam int WINDOW_DEF = 12;

  localparam logic [LIM_W-1:0] LOW_RESET  = 13'd25;
  localparam logic [LIM_W-1:0] HIGH_RESET = 13'd200;
  localparam logic [LIM_W-1:0] DEV_MAX    = 13'd8191;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'd1;

  localparam logic [MODE_W-1:0] MODE_QUAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAIR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_DRAIN,
    ST_VAR,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV,
    ST_DECIDE,
    ST_GRP_RD,
    ST_GRP_DRAIN,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
    logic var_calc;
    logic sqrt_init;
    logic sqrt_step;
    logic div_calc;
    logic dev_load;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_sel;
  } status_t;

endpackage

// ===== src/awa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module awa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/awa_datapath.sv =====
// Datapath: sample scaling, window store, sums, square root, divide, limit registers, mode choice and result registers.
// Depends on awa_pkg and awa_ram.
module awa_datapath #(
  parameter int WINDOW = awa_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  awa_pkg::cmd_t                    cmd,
  input  logic [$clog2(WINDOW)-1:0]        wr_addr,
  input  logic [$clog2(WINDOW)-1:0]        rd_addr,
  input  logic [awa_pkg::SAMPLE_W-1:0]     raw_sample,
  input  logic                             cfg_write,
  input  logic [awa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awa_pkg::LIM_W-1:0]        cfg_data,
  output awa_pkg::status_t                 status,
  output logic [awa_pkg::LUX_W-1:0]        average_lux,
  output logic [awa_pkg::MODE_W-1:0]       mode,
  output logic [awa_pkg::LIM_W-1:0]        deviation_int,
  output logic                             last
);
  import awa_pkg::*;

  localparam int LW  = $clog2(WINDOW);
  localparam int S1W = LUX_W + LW;
  localparam int S2W = 2 * LUX_W + LW;
  localparam int VW  = 2 * S1W;
  localparam int RW  = VW / 2;
  localparam int DW  = RW - 4;
  localparam int PRW = SAMPLE_W + SCALE_W;

  // The root is divided by 16 * WINDOW through a rounded-up reciprocal. The
  // rounding error of DIV_M is below the divisor, so the quotient is exact
  // for every root below 2**RW.
  localparam int DIV_D = 16 * WINDOW;
  localparam int DIV_K = RW + 8;
  localparam int DIV_M = (2 ** DIV_K + DIV_D - 1) / DIV_D;
  localparam int MW    = $clog2(DIV_M + 1);
  localparam int PW    = RW + MW;

  logic [LIM_W-1:0] low_limit;
  logic [LIM_W-1:0] high_limit;

  logic [PRW-1:0]   prod;
  logic [LUX_W-1:0] lux;
  logic [LUX_W-1:0] rd_data;

  logic              rvalid;
  logic              sqv;
  logic [2*LUX_W-1:0] sq;
  logic [S1W-1:0]    acc;
  logic [S2W-1:0]    s2;
  logic [VW-1:0]     ws2;
  logic [VW-1:0]     s1sq;

  logic [VW-1:0]   v;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   root;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;

  logic [PW-1:0]   dprod;
  logic [DW-1:0]   qd;

  logic [LIM_W-1:0]  dev_sat;
  logic [MODE_W-1:0] mode_sel;
  logic [LUX_W-1:0]  avg;

  assign prod = PRW'(raw_sample) * PRW'(LUX_SCALE);
  assign lux  = prod[LUX_SHIFT+LUX_W-1:LUX_SHIFT];

  awa_ram #(
    .WIDTH (LUX_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (lux),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_RESET;
      high_limit <= HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= cfg_data;
        REG_HIGH_LIMIT: high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      sqv    <= 1'b0;
    end else begin
      rvalid <= cmd.rd_en;
      sqv    <= rvalid;
    end
  end

  // Read data is summed as it arrives; squares take one more register stage.
  always_ff @(posedge clk) begin
    sq <= (2*LUX_W)'(rd_data) * (2*LUX_W)'(rd_data);
    if (cmd.acc_clr) begin
      acc <= '0;
      s2  <= '0;
    end else begin
      if (rvalid) begin
        acc <= acc + S1W'(rd_data);
      end
      if (sqv) begin
        s2 <= s2 + S2W'(sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.var_calc) begin
      ws2  <= VW'(VW'(s2) * VW'(WINDOW));
      s1sq <= VW'(acc) * VW'(acc);
    end
  end

  assign rem_sh = {rem[RW-1:0], v[VW-1:VW-2]};
  assign trial  = {root, 2'b01};

  // Digit-by-digit square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      v    <= ws2 - s1sq;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      v <= {v[VW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  assign dprod = PW'(root) * PW'(DIV_M);

  always_ff @(posedge clk) begin
    if (cmd.div_calc) begin
      qd <= DW'(dprod >> DIV_K);
    end
  end

  assign dev_sat = (|qd[DW-1:LIM_W]) ? DEV_MAX : qd[LIM_W-1:0];

  always_comb begin
    if (dev_sat < low_limit) begin
      mode_sel = MODE_QUAD;
    end else if (dev_sat > low_limit && dev_sat < high_limit) begin
      mode_sel = MODE_PAIR;
    end else begin
      mode_sel = MODE_NONE;
    end
  end

  assign status.mode_sel = mode_sel;

  always_ff @(posedge clk) begin
    if (cmd.dev_load) begin
      deviation_int <= dev_sat;
      mode          <= mode_sel;
    end
  end

  always_comb begin
    case (mode)
      MODE_QUAD: avg = acc[LUX_W+1:2];
      MODE_PAIR: avg = acc[LUX_W:1];
      default:   avg = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average_lux <= avg;
      last        <= cmd.out_last;
    end
  end

endmodule

// ===== src/awa_ctrl.sv =====
// Controller state machine: window fill, sequencing of the window-end work and output.
// Depends on awa_pkg.
module awa_ctrl #(
  parameter int WINDOW = awa_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  awa_pkg::status_t           status,
  output awa_pkg::cmd_t              cmd,
  output logic [$clog2(WINDOW)-1:0]  wr_addr,
  output logic [$clog2(WINDOW)-1:0]  rd_addr
);
  import awa_pkg::*;

  localparam int LW  = $clog2(WINDOW);
  localparam int RW  = LUX_W + LW;
  localparam int CW  = $clog2(RW);
  localparam int NQ  = WINDOW / 4;
  localparam int NP  = WINDOW / 2;
  localparam int GW  = $clog2(NP);

  state_t state, state_next;

  logic [LW-1:0]     fill, fill_next;
  logic [LW-1:0]     addr, addr_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [1:0]        ing, ing_next;
  logic [GW-1:0]     grp, grp_next;
  logic [MODE_W-1:0] mode_q, mode_q_next;
  logic              last_q, last_q_next;

  logic [1:0]    gsize_m1;
  logic [GW-1:0] ngrp_m1;
  logic          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign wr_addr  = fill;
  assign rd_addr  = addr;

  assign gsize_m1 = (mode_q == MODE_QUAD) ? 2'd3 : 2'd1;
  assign ngrp_m1  = (mode_q == MODE_QUAD) ? GW'(NQ - 1) : GW'(NP - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      addr   <= '0;
      cnt    <= '0;
      ing    <= '0;
      grp    <= '0;
      mode_q <= MODE_NONE;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      addr   <= addr_next;
      cnt    <= cnt_next;
      ing    <= ing_next;
      grp    <= grp_next;
      mode_q <= mode_q_next;
      last_q <= last_q_next;
    end
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    addr_next   = addr;
    cnt_next    = cnt;
    ing_next    = ing;
    grp_next    = grp;
    mode_q_next = mode_q;
    last_q_next = last_q;
    cmd         = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_en = 1'b1;
          if (fill == LW'(WINDOW - 1)) begin
            fill_next   = '0;
            addr_next   = '0;
            cmd.acc_clr = 1'b1;
            state_next  = ST_SUM;
          end else begin
            fill_next = fill + 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd.rd_en = 1'b1;
        if (addr == LW'(WINDOW - 1)) begin
          cnt_next   = '0;
          state_next = ST_SUM_DRAIN;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      ST_SUM_DRAIN: begin
        // The drain lets the last read reach both the sum and, through the square register, the square sum.
        if (cnt == CW'(1)) begin
          state_next = ST_VAR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_VAR: begin
        cmd.var_calc = 1'b1;
        state_next   = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CW'(RW - 1)) begin
          state_next = ST_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_calc = 1'b1;
        state_next   = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.dev_load = 1'b1;
        cmd.acc_clr  = 1'b1;
        mode_q_next  = status.mode_sel;
        addr_next    = '0;
        ing_next     = '0;
        grp_next     = '0;
        if (status.mode_sel == MODE_NONE) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_GRP_RD;
        end
      end
      ST_GRP_RD: begin
        cmd.rd_en = 1'b1;
        addr_next = addr + 1'b1;
        if (ing == gsize_m1) begin
          ing_next   = '0;
          state_next = ST_GRP_DRAIN;
        end else begin
          ing_next = ing + 1'b1;
        end
      end
      ST_GRP_DRAIN: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.out_load = 1'b1;
        cmd.acc_clr  = 1'b1;
        cmd.out_last = (mode_q == MODE_NONE) || (grp == ngrp_m1);
        last_q_next  = cmd.out_last;
        grp_next     = grp + 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          state_next = last_q ? ST_IDLE : ST_GRP_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/adaptive_window_aggregator.sv =====
// Top level of the adaptive window aggregator: controller plus datapath.
// Depends on awa_pkg, awa_ctrl, awa_datapath and awa_ram.
//
// Usage: raw_sample items enter on in_valid/in_stall; each is scaled to lux
// (Q.4) and written to a window store of WINDOW entries as it is taken, so
// in_stall stays low while the window fills. The item that completes the
// window starts the window-end work and in_stall goes high until the last
// result of that window has been taken.
// For the first result the block reads the store and sums the samples and
// their squares, forms the variance, runs the bit-serial square root, divides
// it by 16 * WINDOW and sets deviation and mode; then it reads and sums the
// first group for averages, or loads the deviation-only item directly. Each
// further result needs its own group of store reads and summing.
// Results appear on out_valid/out_stall from an output register; while
// out_stall is high the result holds and the block waits. last marks the
// final result of a window.
// Configuration (cfg_write, cfg_index, cfg_data) sets the two deviation
// limits; write it only while the block is idle.
// Reset (rst, synchronous) empties the window and restores the limits to 25
// and 200; the store contents need no clearing.
module adaptive_window_aggregator #(
  parameter int WINDOW = awa_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [awa_pkg::SAMPLE_W-1:0]  raw_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [awa_pkg::LUX_W-1:0]     average_lux,
  output logic [awa_pkg::MODE_W-1:0]    mode,
  output logic [awa_pkg::LIM_W-1:0]     deviation_int,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic [awa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [awa_pkg::LIM_W-1:0]     cfg_data
);
  import awa_pkg::*;

  cmd_t                     cmd;
  status_t                  status;
  logic [$clog2(WINDOW)-1:0] wr_addr;
  logic [$clog2(WINDOW)-1:0] rd_addr;

  awa_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  awa_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .raw_sample    (raw_sample),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .average_lux   (average_lux),
    .mode          (mode),
    .deviation_int (deviation_int),
    .last          (last)
  );

endmodule
